>>> rtl/mpd_pkg.sv
// shared types and constants for the mouse packet decoder
`timescale 1ns / 1ps

package mpd_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_PACKET_FOUR   = 3'd0;
    localparam logic [2:0] CFG_EXTRA_BUTTONS = 3'd1;
    localparam logic [2:0] CFG_BOUNDS_ENABLE = 3'd2;
    localparam logic [2:0] CFG_DISP_WIDTH    = 3'd3;
    localparam logic [2:0] CFG_DISP_HEIGHT   = 3'd4;

    localparam logic [14:0] DISP_WIDTH_RESET  = 15'd640;
    localparam logic [14:0] DISP_HEIGHT_RESET = 15'd480;

    // bit positions in the first packet byte
    localparam int SYNC_BIT   = 3;
    localparam int X_SIGN_BIT = 4;
    localparam int Y_SIGN_BIT = 5;
    localparam int X_OVF_BIT  = 6;
    localparam int Y_OVF_BIT  = 7;

    // bit positions in the fourth packet byte
    localparam int BTN4_BIT = 4;
    localparam int BTN5_BIT = 5;

    // event flag bits
    localparam int EVT_MOVE   = 0;
    localparam int EVT_BUTTON = 1;
    localparam int EVT_WHEEL  = 2;

    typedef struct packed {
        logic        packet_four;
        logic        extra_buttons;
        logic        bounds_enable;
        logic [14:0] disp_width;
        logic [14:0] disp_height;
    } cfg_t;

    // one command between the front and back parts
    typedef struct packed {
        logic               is_set;
        logic [4:0]         buttons;
        logic signed [8:0]  move_x;
        logic signed [9:0]  move_y;
        logic signed [3:0]  wheel;
        logic signed [15:0] set_x;
        logic signed [15:0] set_y;
    } cmd_t;

endpackage

>>> rtl/mpd_front.sv
// front part: byte assembly, sync check and packet field decode
`timescale 1ns / 1ps

module mpd_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  mpd_pkg::cfg_t       cfg,
    input  logic                s_valid,
    input  logic                s_ready,
    input  logic                s_req_type,
    input  logic [7:0]          s_data_byte,
    input  logic signed [15:0]  s_set_x,
    input  logic signed [15:0]  s_set_y,
    output logic                push_valid,
    output mpd_pkg::cmd_t       push_cmd
);
    import mpd_pkg::*;

    logic [1:0] byte_count_reg;
    logic [1:0] byte_count_next;
    logic [7:0] store_reg [3];

    logic       accept;
    logic       data_accept;
    logic       sync_ok;
    logic       last_byte;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [9:0] dy_ext;

    assign accept      = s_valid && s_ready;
    assign data_accept = accept && !s_req_type;
    assign sync_ok     = (byte_count_reg != 2'd0) || s_data_byte[SYNC_BIT];
    // a count already at three completes in either packet mode
    assign last_byte   = cfg.packet_four ? (byte_count_reg == 2'd3) : (byte_count_reg >= 2'd2);

    always_comb begin
        b0 = store_reg[0];
        b1 = store_reg[1];
        b2 = (byte_count_reg == 2'd3) ? store_reg[2] : s_data_byte;
        b3 = (cfg.packet_four && byte_count_reg == 2'd3) ? s_data_byte : 8'd0;
        dy_ext = {b0[Y_SIGN_BIT], b0[Y_SIGN_BIT], b2};

        push_cmd.is_set = s_req_type;
        push_cmd.set_x  = s_set_x;
        push_cmd.set_y  = s_set_y;
        push_cmd.buttons = {2'b00, b0[2:0]};
        if (cfg.packet_four && cfg.extra_buttons) begin
            push_cmd.buttons[3] = b3[BTN4_BIT];
            push_cmd.buttons[4] = b3[BTN5_BIT];
        end
        push_cmd.move_x = b0[X_OVF_BIT] ? 9'sd0 : $signed({b0[X_SIGN_BIT], b1});
        push_cmd.move_y = b0[Y_OVF_BIT] ? 10'sd0 : $signed(10'd0 - dy_ext);
        push_cmd.wheel  = cfg.packet_four ? $signed(b3[3:0]) : 4'sd0;
    end

    assign push_valid = accept && (s_req_type || (sync_ok && last_byte));

    always_comb begin
        byte_count_next = byte_count_reg;
        if (data_accept && sync_ok) begin
            byte_count_next = last_byte ? 2'd0 : byte_count_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= 2'd0;
        end else begin
            byte_count_reg <= byte_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (data_accept && sync_ok && !last_byte) begin
            store_reg[byte_count_reg] <= s_data_byte;
        end
    end

endmodule

>>> rtl/mpd_queue.sv
// two-entry command queue between front and back
`timescale 1ns / 1ps

module mpd_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  mpd_pkg::cmd_t push_cmd,
    output logic          not_full,
    input  logic          pop,
    output logic          q_valid,
    output mpd_pkg::cmd_t q_cmd
);
    import mpd_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign not_full = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_cmd    = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> rtl/mpd_back.sv
// back part: cursor accumulation, clamping, flags and result register
`timescale 1ns / 1ps

module mpd_back #(
    parameter int POSITION_WIDTH = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  mpd_pkg::cfg_t      cfg,
    input  logic               q_valid,
    input  mpd_pkg::cmd_t      q_cmd,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [4:0]         m_buttons,
    output logic [4:0]         m_buttons_changed,
    output logic signed [8:0]  m_move_x,
    output logic signed [9:0]  m_move_y,
    output logic signed [3:0]  m_wheel_step,
    output logic signed [15:0] m_cursor_pos_x,
    output logic signed [15:0] m_cursor_pos_y,
    output logic [2:0]         m_event_flags
);
    import mpd_pkg::*;

    // cursor storage must also hold screen coordinates up to 15 bits
    localparam int CW = (POSITION_WIDTH > 16) ? POSITION_WIDTH : 16;
    localparam logic signed [CW:0] POS_HI = {{(CW - POSITION_WIDTH + 2){1'b0}},
                                            {(POSITION_WIDTH - 1){1'b1}}};
    localparam logic signed [CW:0] POS_LO = ~POS_HI;

    function automatic logic signed [CW-1:0] limit_axis(input logic signed [CW:0] v,
                                                        input logic [14:0] size,
                                                        input logic bounds);
        logic signed [CW:0] size_ext;
        logic signed [CW:0] r;
        size_ext = $signed({{(CW - 14){1'b0}}, size});
        r = v;
        if (bounds) begin
            if (r[CW]) begin
                r = '0;
            end
            // an empty screen ends at minus one
            if (r >= size_ext) begin
                r = size_ext - (CW + 1)'(1);
            end
        end else begin
            if (r > POS_HI) begin
                r = POS_HI;
            end
            if (r < POS_LO) begin
                r = POS_LO;
            end
        end
        return r[CW-1:0];
    endfunction

    logic signed [CW-1:0] cur_x_reg;
    logic signed [CW-1:0] cur_y_reg;
    logic [4:0]           last_btn_reg;
    logic                 m_valid_reg;
    logic [4:0]           buttons_reg;
    logic [4:0]           changed_reg;
    logic signed [8:0]    move_x_reg;
    logic signed [9:0]    move_y_reg;
    logic signed [3:0]    wheel_reg;
    logic signed [15:0]   pos_x_reg;
    logic signed [15:0]   pos_y_reg;
    logic [2:0]           flags_reg;

    logic                 pop_pkt;
    logic signed [CW:0]   raw_x;
    logic signed [CW:0]   raw_y;
    logic signed [CW-1:0] cur_x_next;
    logic signed [CW-1:0] cur_y_next;
    logic [2:0]           flags_next;

    assign q_pop   = q_valid && (q_cmd.is_set || !m_valid_reg || m_ready);
    assign pop_pkt = q_pop && !q_cmd.is_set;

    always_comb begin
        if (q_cmd.is_set) begin
            raw_x = $signed({{(CW - 15){q_cmd.set_x[15]}}, q_cmd.set_x});
            raw_y = $signed({{(CW - 15){q_cmd.set_y[15]}}, q_cmd.set_y});
        end else begin
            raw_x = $signed({cur_x_reg[CW-1], cur_x_reg})
                  + $signed({{(CW - 8){q_cmd.move_x[8]}}, q_cmd.move_x});
            raw_y = $signed({cur_y_reg[CW-1], cur_y_reg})
                  + $signed({{(CW - 9){q_cmd.move_y[9]}}, q_cmd.move_y});
        end
        cur_x_next = limit_axis(raw_x, cfg.disp_width, cfg.bounds_enable);
        cur_y_next = limit_axis(raw_y, cfg.disp_height, cfg.bounds_enable);
        flags_next = 3'd0;
        flags_next[EVT_MOVE]   = (q_cmd.move_x != 9'sd0) || (q_cmd.move_y != 10'sd0);
        flags_next[EVT_BUTTON] = (q_cmd.buttons != last_btn_reg);
        flags_next[EVT_WHEEL]  = (q_cmd.wheel != 4'sd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg    <= '0;
            cur_y_reg    <= '0;
            last_btn_reg <= 5'd0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (q_pop) begin
                cur_x_reg <= cur_x_next;
                cur_y_reg <= cur_y_next;
            end
            if (pop_pkt) begin
                last_btn_reg <= q_cmd.buttons;
                m_valid_reg  <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop_pkt) begin
            buttons_reg <= q_cmd.buttons;
            changed_reg <= q_cmd.buttons ^ last_btn_reg;
            move_x_reg  <= q_cmd.move_x;
            move_y_reg  <= q_cmd.move_y;
            wheel_reg   <= q_cmd.wheel;
            pos_x_reg   <= cur_x_next[15:0];
            pos_y_reg   <= cur_y_next[15:0];
            flags_reg   <= flags_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_buttons         = buttons_reg;
    assign m_buttons_changed = changed_reg;
    assign m_move_x          = move_x_reg;
    assign m_move_y          = move_y_reg;
    assign m_wheel_step      = wheel_reg;
    assign m_cursor_pos_x    = pos_x_reg;
    assign m_cursor_pos_y    = pos_y_reg;
    assign m_event_flags     = flags_reg;

`ifndef SYNTHESIS
    a_pkt_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        pop_pkt |=> m_valid_reg)
        else $error("packet popped without a result");
    a_button_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (flags_reg[EVT_BUTTON] == (changed_reg != 5'd0)))
        else $error("button flag disagrees with change mask");
    a_move_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (flags_reg[EVT_MOVE] ==
                         ((move_x_reg != 9'sd0) || (move_y_reg != 10'sd0))))
        else $error("movement flag disagrees with deltas");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !pop_pkt)
        else $error("pending result overwritten");
`endif

endmodule

>>> rtl/mouse_packet_decoder.sv
// mouse packet decoder top level: configuration registers and part wiring
// a packet is queued, then its pop loads the registered result behind m_valid
// throughput: one transaction per cycle while no result waits on m_ready
// a two-entry queue lets byte intake run while a result waits on m_ready
// reset (aresetn low, synchronous) clears byte count, cursor, button history,
// the queue and the result valid, and loads configuration defaults; no clearing pass
`timescale 1ns / 1ps

module mouse_packet_decoder #(
    parameter int POSITION_WIDTH = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_addr,
    input  logic [14:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_req_type,
    input  logic [7:0]         s_data_byte,
    input  logic signed [15:0] s_set_x,
    input  logic signed [15:0] s_set_y,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [4:0]         m_buttons,
    output logic [4:0]         m_buttons_changed,
    output logic signed [8:0]  m_move_x,
    output logic signed [9:0]  m_move_y,
    output logic signed [3:0]  m_wheel_step,
    output logic signed [15:0] m_cursor_pos_x,
    output logic signed [15:0] m_cursor_pos_y,
    output logic [2:0]         m_event_flags
);
    import mpd_pkg::*;

    cfg_t cfg_reg;
    logic push_valid;
    cmd_t push_cmd;
    logic q_valid;
    logic q_pop;
    cmd_t q_cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.packet_four   <= 1'b0;
            cfg_reg.extra_buttons <= 1'b0;
            cfg_reg.bounds_enable <= 1'b0;
            cfg_reg.disp_width    <= DISP_WIDTH_RESET;
            cfg_reg.disp_height   <= DISP_HEIGHT_RESET;
        end else if (cfg_valid) begin
            case (cfg_addr)
                CFG_PACKET_FOUR:   cfg_reg.packet_four   <= cfg_data[0];
                CFG_EXTRA_BUTTONS: cfg_reg.extra_buttons <= cfg_data[0];
                CFG_BOUNDS_ENABLE: cfg_reg.bounds_enable <= cfg_data[0];
                CFG_DISP_WIDTH:    cfg_reg.disp_width    <= cfg_data;
                CFG_DISP_HEIGHT:   cfg_reg.disp_height   <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    mpd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_data_byte (s_data_byte),
        .s_set_x     (s_set_x),
        .s_set_y     (s_set_y),
        .push_valid  (push_valid),
        .push_cmd    (push_cmd)
    );

    mpd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push_valid),
        .push_cmd (push_cmd),
        .not_full (s_ready),
        .pop      (q_pop),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    mpd_back #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg               (cfg_reg),
        .q_valid           (q_valid),
        .q_cmd             (q_cmd),
        .q_pop             (q_pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_buttons         (m_buttons),
        .m_buttons_changed (m_buttons_changed),
        .m_move_x          (m_move_x),
        .m_move_y          (m_move_y),
        .m_wheel_step      (m_wheel_step),
        .m_cursor_pos_x    (m_cursor_pos_x),
        .m_cursor_pos_y    (m_cursor_pos_y),
        .m_event_flags     (m_event_flags)
    );

endmodule
